### rtl/kbtbo_pkg.sv
package kbtbo_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BEST_MODE = 2'd0;

   localparam logic [1:0] CMD_PLACE    = 2'd0;
   localparam logic [1:0] CMD_WITHDRAW = 2'd1;
   localparam logic [1:0] CMD_QUERY    = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_FILL_W = 2;

   typedef struct packed {
      logic [1:0]         command;
      logic [15:0]        contractor_id;
      logic signed [31:0] offer_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] best_offer;
      logic [1:0]         status;
      logic [4:0]         bid_count;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        key;
      logic signed [31:0] offer;
   } op_type;

   typedef struct packed {
      logic   avail;
      op_type op;
   } q_head_type;

endpackage

### rtl/kbtbo_front.sv
module kbtbo_front #(
   parameter int KEY_W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  kbtbo_pkg::req_word_type req_word,
   output kbtbo_pkg::q_head_type   head,
   input  logic                    pop
);

   localparam logic [15:0] KEY_MASK = 16'((17'd1 << KEY_W) - 17'd1);

   kbtbo_pkg::op_type                  q_ff [kbtbo_pkg::Q_DEPTH];
   logic [kbtbo_pkg::Q_PTR_W-1:0]      wr_ptr_ff;
   logic [kbtbo_pkg::Q_PTR_W-1:0]      rd_ptr_ff;
   logic [kbtbo_pkg::Q_FILL_W-1:0]     fill_ff;
   logic [kbtbo_pkg::Q_FILL_W-1:0]     fill_in;
   logic                               push;
   logic                               do_pop;
   kbtbo_pkg::op_type                  op_in;

   // classify: unused codes stay as they are and are ignored downstream
   always_comb begin
      op_in.kind  = req_word.command;
      op_in.key   = req_word.contractor_id & KEY_MASK;
      op_in.offer = req_word.offer_value;
   end

   assign busy   = (fill_ff == kbtbo_pkg::Q_FILL_W'(kbtbo_pkg::Q_DEPTH));
   assign push   = start && !busy;
   assign do_pop = pop && (fill_ff != '0);

   always_comb begin
      fill_in = fill_ff;
      if (push && !do_pop) begin
         fill_in = fill_ff + kbtbo_pkg::Q_FILL_W'(1);
      end else if (do_pop && !push) begin
         fill_in = fill_ff - kbtbo_pkg::Q_FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + kbtbo_pkg::Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + kbtbo_pkg::Q_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_in;
      end
   end

   always_comb begin
      head.avail = (fill_ff != '0);
      head.op    = q_ff[rd_ptr_ff];
   end

endmodule

### rtl/kbtbo_back.sv
module kbtbo_back #(
   parameter int MAX_BIDS = 16,
   parameter int KEY_W    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    best_mode,
   input  kbtbo_pkg::q_head_type   head,
   output logic                    pop,
   output logic                    rsp_valid,
   output kbtbo_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(MAX_BIDS);
   localparam int CNT_W = $clog2(MAX_BIDS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BIDS - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   kbtbo_pkg::op_type       op_ff;

   logic [KEY_W-1:0]        key_mem [MAX_BIDS];
   logic signed [31:0]      off_mem [MAX_BIDS];
   logic [MAX_BIDS-1:0]     valid_ff, valid_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic [IDX_W-1:0]        addr_ff;
   logic                    issue_ff;
   logic                    rd_go_ff;
   logic                    rd_last_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    rd_vld_ff;
   logic [KEY_W-1:0]        rd_key_ff;
   logic signed [31:0]      rd_off_ff;

   logic                    hit_ff, free_ff, have_ff;
   logic [IDX_W-1:0]        hit_idx_ff, free_idx_ff;
   logic signed [31:0]      best_ff;

   logic                    match, free_seen, better;
   logic                    mem_we;
   logic [IDX_W-1:0]        wr_idx;
   logic [1:0]              status;
   logic signed [31:0]      best_out;
   logic [CNT_W+4:0]        cnt_wide;

   logic                    rsp_valid_ff;
   kbtbo_pkg::rsp_word_type rsp_word_ff;

   assign pop = (state_ff == S_IDLE) && head.avail;

   assign match     = rd_go_ff && rd_vld_ff && !hit_ff && (rd_key_ff == op_ff.key[KEY_W-1:0]);
   assign free_seen = rd_go_ff && !rd_vld_ff && !free_ff;
   assign better    = rd_go_ff && rd_vld_ff &&
                      (!have_ff || (best_mode ? (rd_off_ff < best_ff) : (rd_off_ff > best_ff)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.avail) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_go_ff && rd_last_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // write-back and result
   always_comb begin
      mem_we   = 1'b0;
      wr_idx   = hit_idx_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      status   = kbtbo_pkg::ST_OK;
      best_out = '0;
      if (state_ff == S_DONE) begin
         case (op_ff.kind)
            kbtbo_pkg::CMD_PLACE: begin
               if (hit_ff) begin
                  mem_we = 1'b1;
               end else if (free_ff) begin
                  mem_we           = 1'b1;
                  wr_idx           = free_idx_ff;
                  valid_in[wr_idx] = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end else begin
                  status = kbtbo_pkg::ST_FULL;
               end
            end
            kbtbo_pkg::CMD_WITHDRAW: begin
               if (hit_ff) begin
                  valid_in[wr_idx] = 1'b0;
                  count_in         = count_ff - CNT_W'(1);
               end else begin
                  status = kbtbo_pkg::ST_NOT_FOUND;
               end
            end
            kbtbo_pkg::CMD_QUERY: begin
               if (have_ff) begin
                  best_out = best_ff;
               end else begin
                  status = kbtbo_pkg::ST_EMPTY;
               end
            end
            default: begin
               status = kbtbo_pkg::ST_OK;
            end
         endcase
      end
   end

   assign cnt_wide = {5'b0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         rd_go_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rd_go_ff     <= (state_ff == S_SCAN) && issue_ff;
         rsp_valid_ff <= (state_ff == S_DONE);
         if (pop) begin
            issue_ff <= 1'b1;
            hit_ff   <= 1'b0;
            free_ff  <= 1'b0;
            have_ff  <= 1'b0;
         end else begin
            if ((state_ff == S_SCAN) && issue_ff && (addr_ff == LAST_IDX)) begin
               issue_ff <= 1'b0;
            end
            if (match) begin
               hit_ff <= 1'b1;
            end
            if (free_seen) begin
               free_ff <= 1'b1;
            end
            if (better) begin
               have_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff   <= head.op;
         addr_ff <= '0;
      end else if ((state_ff == S_SCAN) && issue_ff) begin
         addr_ff <= addr_ff + IDX_W'(1);
      end
      if (match) begin
         hit_idx_ff <= rd_idx_ff;
      end
      if (free_seen) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (better) begin
         best_ff <= rd_off_ff;
      end
      rd_idx_ff  <= addr_ff;
      rd_last_ff <= (addr_ff == LAST_IDX);
      rd_vld_ff  <= valid_ff[addr_ff];
      if (state_ff == S_DONE) begin
         rsp_word_ff.best_offer <= best_out;
         rsp_word_ff.status     <= status;
         rsp_word_ff.bid_count  <= cnt_wide[4:0];
      end
   end

   // bid store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_idx] <= op_ff.key[KEY_W-1:0];
         off_mem[wr_idx] <= op_ff.offer;
      end
      rd_key_ff <= key_mem[addr_ff];
      rd_off_ff <= off_mem[addr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### rtl/keyed_bid_table_best_offer.sv
// each word is handled in turn by a scan of the whole store, one entry per cycle
// a two-word command queue takes starts while the scan runs; busy is high when it is full
// reset (synchronous, active high) empties the table, the queue and best_mode
// rsp_valid is a one-cycle strobe; the receiver cannot stall
module keyed_bid_table_best_offer #(
   parameter int MAX_BIDS        = 16,
   parameter int CONTRACTOR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  kbtbo_pkg::req_word_type              req_word,
   output logic                                 rsp_valid,
   output kbtbo_pkg::rsp_word_type              rsp_word,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [kbtbo_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int KEY_W = (CONTRACTOR_BITS < 16) ? CONTRACTOR_BITS : 16;

   logic                  best_mode_ff;
   logic                  pop;
   kbtbo_pkg::q_head_type head;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready &&
                   (paddr == kbtbo_pkg::CSR_BEST_MODE)) begin
         best_mode_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr == kbtbo_pkg::CSR_BEST_MODE) ? {31'b0, best_mode_ff} : '0;

   kbtbo_front #(
      .KEY_W (KEY_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .head     (head),
      .pop      (pop)
   );

   kbtbo_back #(
      .MAX_BIDS (MAX_BIDS),
      .KEY_W    (KEY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .best_mode (best_mode_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

### rtl/kbtbo_checker.sv
module kbtbo_checker #(
   parameter int MAX_BIDS = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    busy,
   input logic                    rsp_valid,
   input kbtbo_pkg::rsp_word_type rsp_word
);

   // each word needs a full scan, so strobes never come back to back
   a_strobe_gap: assert property (@(posedge clock) rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("busy or strobe right after reset");

   a_zero_offer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != kbtbo_pkg::ST_OK) |-> rsp_word.best_offer == '0)
      else $error("nonzero offer on a failed command");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (MAX_BIDS < 32) |-> (32'(rsp_word.bid_count) <= 32'(MAX_BIDS)))
      else $error("bid count above table size");

endmodule

bind keyed_bid_table_best_offer kbtbo_checker #(
   .MAX_BIDS (MAX_BIDS)
) u_kbtbo_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_BIDS        = 16;
   localparam int CONTRACTOR_BITS = 16;
   localparam int KEY_POOL        = 24;
   localparam int PHASE_WORDS     = 100;
   localparam int CYCLE_LIMIT     = 300000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   class bid_book;
      bit                      slot_used[MAX_BIDS];
      logic [15:0]             slot_key[MAX_BIDS];
      logic signed [31:0]      slot_offer[MAX_BIDS];
      bit                      lowest_wins;
      kbtbo_pkg::rsp_word_type pending_answers[$];
      int                      fails;
      int                      words_checked;
      int                      status_seen[4];

      function int find_slot(logic [15:0] key);
         int slot;
         slot = -1;
         for (int i = MAX_BIDS - 1; i >= 0; i--)
            if (slot_used[i] && slot_key[i] == key) slot = i;
         return slot;
      endfunction

      function void note_word(kbtbo_pkg::req_word_type w);
         kbtbo_pkg::rsp_word_type ans;
         int                      slot;
         int                      n;
         bit                      have;
         logic signed [31:0]      top;
         ans = '0;
         ans.status = kbtbo_pkg::ST_OK;
         have = 1'b0;
         top = '0;
         n = 0;
         case (w.command)
            kbtbo_pkg::CMD_PLACE: begin
               slot = find_slot(w.contractor_id);
               if (slot < 0)
                  for (int i = MAX_BIDS - 1; i >= 0; i--)
                     if (!slot_used[i]) slot = i;
               if (slot < 0) begin
                  ans.status = kbtbo_pkg::ST_FULL;
               end else begin
                  slot_used[slot]  = 1'b1;
                  slot_key[slot]   = w.contractor_id;
                  slot_offer[slot] = w.offer_value;
               end
            end
            kbtbo_pkg::CMD_WITHDRAW: begin
               slot = find_slot(w.contractor_id);
               if (slot < 0) ans.status = kbtbo_pkg::ST_NOT_FOUND;
               else slot_used[slot] = 1'b0;
            end
            kbtbo_pkg::CMD_QUERY: begin
               for (int i = 0; i < MAX_BIDS; i++)
                  if (slot_used[i] &&
                      (!have || (lowest_wins ? slot_offer[i] < top : slot_offer[i] > top))) begin
                     top  = slot_offer[i];
                     have = 1'b1;
                  end
               if (!have) ans.status = kbtbo_pkg::ST_EMPTY;
               else ans.best_offer = top;
            end
            default: ;
         endcase
         for (int i = 0; i < MAX_BIDS; i++)
            if (slot_used[i]) n++;
         ans.bid_count = n[4:0];
         pending_answers = {pending_answers, ans};
      endfunction

      function void check_word(kbtbo_pkg::rsp_word_type got);
         kbtbo_pkg::rsp_word_type want;
         if (pending_answers.size() == 0) begin
            $error("result word with nothing pending: best_offer %0d status %0d bid_count %0d",
                   got.best_offer, got.status, got.bid_count);
            fails++;
            return;
         end
         want = pending_answers.pop_front();
         words_checked++;
         status_seen[want.status]++;
         if (got.best_offer !== want.best_offer) begin
            $error("best_offer: expected %0d, got %0d", want.best_offer, got.best_offer);
            fails++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
         end
         if (got.bid_count !== want.bid_count) begin
            $error("bid_count: expected %0d, got %0d", want.bid_count, got.bid_count);
            fails++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   kbtbo_pkg::req_word_type          req_word = '0;
   logic                             rsp_valid;
   kbtbo_pkg::rsp_word_type          rsp_word;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [kbtbo_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                      pwdata = '0;
   logic [31:0]                      prdata;
   logic                             pready;

   bid_book     book;
   logic [15:0] key_pool[KEY_POOL];
   int          cycles = 0;

   keyed_bid_table_best_offer #(
      .MAX_BIDS(MAX_BIDS),
      .CONTRACTOR_BITS(CONTRACTOR_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) book.check_word(rsp_word);
   end

   // write best_mode, then read it back in the next transfer
   task automatic set_best_mode(input bit lowest);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= kbtbo_pkg::CSR_BEST_MODE;
      pwdata  <= {31'b0, lowest};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      book.lowest_wins = lowest;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {31'b0, lowest}) begin
         $error("best_mode readback: expected %0d, got %0d", lowest, prdata);
         book.fails++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_word(input kbtbo_pkg::req_word_type w, input bit no_idle);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      book.note_word(w);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (book.pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic kbtbo_pkg::req_word_type word_of(logic [1:0] cmd, logic [15:0] key,
                                                       logic [31:0] offer);
      kbtbo_pkg::req_word_type w;
      w.command       = cmd;
      w.contractor_id = key;
      w.offer_value   = offer;
      return w;
   endfunction

   function automatic kbtbo_pkg::req_word_type random_word(bit fill_bias);
      kbtbo_pkg::req_word_type w;
      int                      pick;
      pick = $urandom_range(0, 99);
      if (pick < (fill_bias ? 55 : 25)) w.command = kbtbo_pkg::CMD_PLACE;
      else if (pick < (fill_bias ? 75 : 65)) w.command = kbtbo_pkg::CMD_WITHDRAW;
      else if (pick < 95) w.command = kbtbo_pkg::CMD_QUERY;
      else w.command = CMD_UNUSED;
      if ($urandom_range(0, 99) < 85) w.contractor_id = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else w.contractor_id = 16'($urandom);
      case ($urandom_range(0, 7))
         0: w.offer_value = 32'h7fff_ffff;
         1: w.offer_value = 32'h8000_0000;
         // a few close values so that ties show up
         2: w.offer_value = 32'($urandom_range(0, 3)) - 32'd2;
         default: w.offer_value = $urandom;
      endcase
      return w;
   endfunction

   initial begin
      book = new;
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hffff;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = 16'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_best_mode(1'b0);

      send_word(word_of(kbtbo_pkg::CMD_QUERY, 16'h1234, 32'h0), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_WITHDRAW, 16'hffff, 32'h0), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_PLACE, 16'h0000, 32'h7fff_ffff), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_PLACE, 16'hffff, 32'h8000_0000), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_PLACE, 16'h5555, 32'h0), 1'b1);
      send_word(word_of(kbtbo_pkg::CMD_QUERY, 16'haaaa, 32'hffff_ffff), 1'b1);
      send_word(word_of(CMD_UNUSED, 16'hffff, 32'hffff_ffff), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_PLACE, 16'h0000, 32'hffff_ffff), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_WITHDRAW, 16'hffff, 32'h0), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_QUERY, 16'h0, 32'h0), 1'b0);
      for (int i = 0; i < MAX_BIDS - 2; i++)
         send_word(word_of(kbtbo_pkg::CMD_PLACE, 16'h0100 + 16'(i), 32'h0001_0000 * i), 1'b1);
      send_word(word_of(kbtbo_pkg::CMD_PLACE, 16'h0200, 32'h7fff_ffff), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_PLACE, 16'h5555, 32'h8000_0000), 1'b0);
      send_word(word_of(kbtbo_pkg::CMD_QUERY, 16'h0, 32'h0), 1'b0);
      drain();

      for (int p = 0; p < 6; p++) begin
         set_best_mode(p % 2 == 0);
         for (int k = 0; k < PHASE_WORDS; k++)
            send_word(random_word(p % 3 != 1), p == 2 || p == 5);
         drain();
      end

      repeat (MAX_BIDS + 8) @(posedge clock);
      $display("checked %0d result words over %0d cycles, both best_mode settings",
               book.words_checked, cycles);
      $display("status counts: ok %0d, full %0d, not found %0d, empty %0d",
               book.status_seen[kbtbo_pkg::ST_OK], book.status_seen[kbtbo_pkg::ST_FULL],
               book.status_seen[kbtbo_pkg::ST_NOT_FOUND], book.status_seen[kbtbo_pkg::ST_EMPTY]);
      if (book.fails == 0 && book.pending_answers.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
